@@ design/four_voice_dma_sample_player_core_defines.svh @@
// ============================================================================
// Four-voice sample player assertion macros
// Shared property shorthands for the port-level checker.
// ============================================================================
`ifndef FOUR_VOICE_DMA_SAMPLE_PLAYER_CORE_DEFINES_SVH
`define FOUR_VOICE_DMA_SAMPLE_PLAYER_CORE_DEFINES_SVH

// next-cycle implication, disabled in reset
`define FVDSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fvdsp next-cycle check failed");

// same-cycle implication, active through reset
`define FVDSP_ASSERT_NOW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("fvdsp same-cycle check failed");

`endif

@@ design/fvdsp_pkg.sv @@
// ============================================================================
// Four-voice sample player package
// Shared constants, codes, word types and helper functions.
// ============================================================================
`default_nettype none

package fvdsp_pkg;

   localparam int VOICES     = 4;
   localparam int VOICE_W    = $clog2(VOICES);
   localparam logic [VOICE_W-1:0] VOICE_LAST = VOICE_W'(VOICES - 1);
   localparam int MEM_BYTES  = 65536;
   localparam int MEM_AW     = $clog2(MEM_BYTES);
   localparam int BANK_DEPTH = MEM_BYTES / 2;
   localparam int BANK_AW    = MEM_AW - 1;
   localparam int PTR_W      = 21;
   localparam int DATA_W     = 16;
   localparam int VOL_W      = 7;
   localparam int SAMPLE_W   = 14;
   localparam logic [VOL_W-1:0] VOL_MAX = 7'd64;

   localparam logic [2:0] OP_REG_WRITE  = 3'd0;
   localparam logic [2:0] OP_REG_READ   = 3'd1;
   localparam logic [2:0] OP_SET_DMA    = 3'd2;
   localparam logic [2:0] OP_SET_ATTACH = 3'd3;
   localparam logic [2:0] OP_TICK       = 3'd4;
   localparam logic [2:0] OP_MEM_WRITE  = 3'd5;

   localparam logic [2:0] REG_PTR_HIGH = 3'd0;
   localparam logic [2:0] REG_PTR_LOW  = 3'd1;
   localparam logic [2:0] REG_LENGTH   = 3'd2;
   localparam logic [2:0] REG_PERIOD   = 3'd3;
   localparam logic [2:0] REG_VOLUME   = 3'd4;
   localparam logic [2:0] REG_DATA     = 3'd5;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_READY  = 3'd1,
      MODE_HIGH   = 3'd2,
      MODE_LOW    = 3'd3,
      MODE_MREADY = 3'd4,
      MODE_MHIGH  = 3'd5,
      MODE_MLOW   = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OP,
      ST_VOICE_READ,
      ST_VOICE_UPDATE,
      ST_MIX,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  channel;
      logic [2:0]  reg_index;
      logic [15:0] value;
      logic        dma_master;
      logic [3:0]  dma_voice_mask;
      logic [3:0]  volume_attach;
      logic [3:0]  period_attach;
      logic [19:0] mem_address;
      logic [7:0]  mem_byte;
   } req_type;

   typedef struct packed {
      logic [15:0]        read_data;
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               sample_valid;
      logic [3:0]         irq_flags;
      logic [3:0]         voices_active;
   } rsp_type;

   typedef struct packed {
      logic               clear;
      logic               accept;
      logic               exec;
      logic               voice_up;
      logic               mix;
      logic               out_load;
      logic [VOICE_W-1:0] voice;
      logic [BANK_AW-1:0] clear_addr;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic step_due;
   } status_type;

   function automatic logic [VOL_W-1:0] clamp_vol(input logic [DATA_W-1:0] v);
      logic [VOL_W-1:0] low;
      low = v[VOL_W-1:0];
      return (low > VOL_MAX) ? VOL_MAX : low;
   endfunction

   function automatic logic [SAMPLE_W-1:0] scale_sample(input logic [7:0] b,
                                                         input logic [VOL_W-1:0] vol);
      logic signed [15:0] p;
      p = $signed(b) * $signed({1'b0, vol});
      return p[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/fvdsp_ctrl.sv @@
// ============================================================================
// Four-voice sample player controller
// Sequences memory clear, operation decode, per-voice steps and result hand-off.
// ============================================================================
`default_nettype none

module fvdsp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  fvdsp_pkg::status_type  status,
   output fvdsp_pkg::cmd_type     cmd
);
   import fvdsp_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [VOICE_W-1:0] voice_ff, voice_in;
   logic [BANK_AW-1:0] clear_ff, clear_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      voice_in       = voice_ff;
      clear_in       = clear_ff;
      cmd            = '0;
      cmd.voice      = voice_ff;
      cmd.clear_addr = clear_ff;
      req_stall      = 1'b1;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            clear_in  = clear_ff + 1'b1;
            if (clear_ff == BANK_AW'(BANK_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_OP;
            end
         end
         ST_OP: begin
            cmd.exec = 1'b1;
            voice_in = '0;
            if (status.is_tick && status.step_due) state_in = ST_VOICE_READ;
            else state_in = ST_DONE;
         end
         ST_VOICE_READ: begin
            state_in = ST_VOICE_UPDATE;
         end
         ST_VOICE_UPDATE: begin
            cmd.voice_up = 1'b1;
            if (voice_ff == VOICE_LAST) begin
               state_in = ST_MIX;
            end else begin
               voice_in = voice_ff + 1'b1;
               state_in = ST_VOICE_READ;
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         voice_ff     <= '0;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         voice_ff     <= voice_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ design/fvdsp_datapath.sv @@
// ============================================================================
// Four-voice sample player datapath
// Voice registers, sample memory banks, voice step logic, mixer and result word.
// ============================================================================
`default_nettype none

module fvdsp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  fvdsp_pkg::req_type    req_data,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   input  fvdsp_pkg::cmd_type    cmd,
   output fvdsp_pkg::status_type status,
   output fvdsp_pkg::rsp_type    rsp_data
);
   import fvdsp_pkg::*;

   req_type                    req_ff;
   logic [DATA_W-1:0]          divider_ff;
   logic [DATA_W-1:0]          tick_ff, tick_in;

   logic [PTR_W-1:0]           start_ff [VOICES], start_in [VOICES];
   logic [DATA_W-1:0]          len_ff [VOICES], len_in [VOICES];
   logic [DATA_W-1:0]          period_ff [VOICES], period_in [VOICES];
   logic [VOL_W-1:0]           vol_ff [VOICES], vol_in [VOICES];
   logic [DATA_W-1:0]          data_ff [VOICES], data_in [VOICES];
   logic [PTR_W-1:0]           live_ff [VOICES], live_in [VOICES];
   logic [DATA_W-1:0]          wl_ff [VOICES], wl_in [VOICES];
   mode_type                   mode_ff [VOICES], mode_in [VOICES];
   logic [DATA_W-1:0]          cw_ff [VOICES], cw_in [VOICES];
   logic [DATA_W-1:0]          pc_ff [VOICES], pc_in [VOICES];
   logic [SAMPLE_W-1:0]        held_ff [VOICES], held_in [VOICES];
   logic [VOICES-1:0]          dma_on_ff, dma_on_in;
   logic [VOICES-1:0]          mvn_ff, mvn_in;
   logic                       master_ff, master_in;
   logic [2*VOICES-1:0]        attach_ff, attach_in;
   logic [VOICES-1:0]          irq_ff, irq_in;
   logic signed [DATA_W-1:0]   left_ff, left_in, right_ff, right_in;
   logic [DATA_W-1:0]          read_ff, read_in;
   logic                       valid_ff, valid_in;
   rsp_type                    rsp_ff;

   logic [7:0]                 even_mem [BANK_DEPTH];
   logic [7:0]                 odd_mem [BANK_DEPTH];
   logic [7:0]                 even_q_ff, odd_q_ff;

   logic [VOICES-1:0]          va_mask, pa_mask, att;
   logic [VOICE_W-1:0]         vi;
   logic [1:0]                 ci;
   logic [DATA_W-1:0]          wl_dec;
   logic                       wrap;
   logic [PTR_W-1:0]           fetch_addr;
   logic [DATA_W-1:0]          mem_word;
   logic [DATA_W:0]            tick_sum;
   logic                       due;
   logic signed [SAMPLE_W-1:0] vout [VOICES];
   logic [VOICES-1:0]          active;
   logic                       mem_wr, even_we, odd_we;
   logic [BANK_AW-1:0]         wr_idx, rd_idx;
   logic [7:0]                 wr_byte;

   assign va_mask  = attach_ff[VOICES-1:0];
   assign pa_mask  = attach_ff[2*VOICES-1:VOICES];
   assign att      = va_mask | pa_mask;
   assign vi       = cmd.voice;
   assign ci       = req_ff.channel;
   assign wl_dec   = (wl_ff[vi] != '0) ? wl_ff[vi] - 1'b1 : '0;
   assign wrap     = (mode_ff[vi] == MODE_LOW) && (wl_dec == '0);
   assign fetch_addr = wrap ? start_ff[vi] : live_ff[vi];
   assign mem_word = {even_q_ff, odd_q_ff};
   assign tick_sum = {1'b0, tick_ff} + 1'b1;
   assign due      = tick_sum >= {1'b0, divider_ff};

   assign status.is_tick  = (req_ff.op == OP_TICK);
   assign status.step_due = due;

   always_comb begin
      for (int k = 0; k < VOICES; k++) begin
         active[k] = (mode_ff[k] != MODE_IDLE);
         if (att[k] || mode_ff[k] == MODE_IDLE || mode_ff[k] == MODE_READY ||
             mode_ff[k] == MODE_MREADY) vout[k] = '0;
         else vout[k] = held_ff[k];
      end
   end

   always_comb begin
      mode_type           m;
      logic [DATA_W-1:0]  reload, pc0, pc1, mod_word;
      logic               adv, mod_en, lat_en, va, pa, was, now;
      logic [7:0]         lat_byte;
      logic [VOICE_W-1:0] t;

      start_in  = start_ff;
      len_in    = len_ff;
      period_in = period_ff;
      vol_in    = vol_ff;
      data_in   = data_ff;
      live_in   = live_ff;
      wl_in     = wl_ff;
      mode_in   = mode_ff;
      cw_in     = cw_ff;
      pc_in     = pc_ff;
      held_in   = held_ff;
      dma_on_in = dma_on_ff;
      mvn_in    = mvn_ff;
      master_in = master_ff;
      attach_in = attach_ff;
      irq_in    = irq_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      read_in   = read_ff;
      valid_in  = valid_ff;
      tick_in   = tick_ff;

      t        = vi + 1'b1;
      m        = mode_ff[vi];
      reload   = (period_ff[vi] == '0) ? DATA_W'(1) : period_ff[vi];
      pc0      = (pc_ff[vi] == '0) ? reload : pc_ff[vi];
      pc1      = pc0 - 1'b1;
      adv      = 1'b0;
      mod_en   = 1'b0;
      mod_word = mem_word;
      lat_en   = 1'b0;
      lat_byte = mem_word[15:8];
      va       = 1'b0;
      pa       = 1'b0;
      was      = 1'b0;
      now      = 1'b0;

      if (cmd.voice_up) begin
         case (m)
            MODE_IDLE: adv = 1'b0;
            MODE_READY, MODE_MREADY: adv = 1'b1;
            default: begin
               pc_in[vi] = pc1;
               adv       = (pc1 == '0);
            end
         endcase
         if (adv) begin
            case (m)
               MODE_READY, MODE_LOW: begin
                  if (m == MODE_LOW) begin
                     wl_in[vi] = wl_dec;
                     if (wrap) begin
                        wl_in[vi]  = len_ff[vi];
                        irq_in[vi] = 1'b1;
                     end
                  end
                  cw_in[vi]   = mem_word;
                  live_in[vi] = fetch_addr + PTR_W'(2);
                  mod_en      = att[vi];
                  mod_word    = mem_word;
                  lat_byte    = mem_word[15:8];
                  lat_en      = 1'b1;
                  mode_in[vi] = MODE_HIGH;
                  pc_in[vi]   = reload;
               end
               MODE_HIGH: begin
                  lat_byte    = cw_ff[vi][7:0];
                  lat_en      = 1'b1;
                  mode_in[vi] = MODE_LOW;
                  pc_in[vi]   = reload;
               end
               MODE_MHIGH: begin
                  lat_byte    = cw_ff[vi][7:0];
                  lat_en      = 1'b1;
                  mode_in[vi] = MODE_MLOW;
                  pc_in[vi]   = reload;
               end
               MODE_MREADY: begin
                  mod_en      = att[vi];
                  mod_word    = cw_ff[vi];
                  lat_byte    = cw_ff[vi][15:8];
                  lat_en      = 1'b1;
                  mode_in[vi] = att[vi] ? MODE_MLOW : MODE_MHIGH;
                  pc_in[vi]   = reload;
               end
               MODE_MLOW: begin
                  irq_in[vi]  = 1'b1;
                  mode_in[vi] = MODE_IDLE;
               end
               default: adv = 1'b0;
            endcase
         end
         if (lat_en) held_in[vi] = att[vi] ? '0 : scale_sample(lat_byte, vol_ff[vi]);
         if (mod_en && vi != VOICE_LAST) begin
            va = va_mask[vi];
            pa = pa_mask[vi];
            if (va && pa) begin
               if (mvn_ff[vi]) vol_in[t] = clamp_vol(mod_word);
               else period_in[t] = mod_word;
               mvn_in[vi] = !mvn_ff[vi];
            end else if (va) begin
               vol_in[t] = clamp_vol(mod_word);
            end else if (pa) begin
               period_in[t] = mod_word;
            end
         end
      end

      if (cmd.mix) begin
         left_in  = DATA_W'(vout[0]) + DATA_W'(vout[3]);
         right_in = DATA_W'(vout[1]) + DATA_W'(vout[2]);
      end

      if (cmd.exec) begin
         read_in  = '0;
         valid_in = 1'b0;
         case (req_ff.op)
            OP_REG_WRITE: begin
               case (req_ff.reg_index)
                  REG_PTR_HIGH: start_in[ci] = {req_ff.value[PTR_W-17:0],
                                                start_ff[ci][15:1], 1'b0};
                  REG_PTR_LOW:  start_in[ci] = {start_ff[ci][PTR_W-1:16],
                                                req_ff.value[15:1], 1'b0};
                  REG_LENGTH:   len_in[ci] = req_ff.value;
                  REG_PERIOD:   period_in[ci] = req_ff.value;
                  REG_VOLUME:   vol_in[ci] = clamp_vol(req_ff.value);
                  REG_DATA: begin
                     data_in[ci] = req_ff.value;
                     if (!master_ff || !dma_on_ff[ci]) begin
                        cw_in[ci]   = req_ff.value;
                        wl_in[ci]   = '0;
                        live_in[ci] = '0;
                        pc_in[ci]   = '0;
                        mode_in[ci] = MODE_MREADY;
                     end
                  end
                  default: read_in = '0;
               endcase
            end
            OP_REG_READ: begin
               case (req_ff.reg_index)
                  REG_PTR_HIGH: read_in = DATA_W'(start_ff[ci][PTR_W-1:16]);
                  REG_PTR_LOW:  read_in = {start_ff[ci][15:1], 1'b0};
                  REG_LENGTH:   read_in = len_ff[ci];
                  REG_PERIOD:   read_in = period_ff[ci];
                  REG_VOLUME:   read_in = DATA_W'(vol_ff[ci]);
                  REG_DATA:     read_in = data_ff[ci];
                  default:      read_in = '0;
               endcase
            end
            OP_SET_DMA: begin
               master_in = req_ff.dma_master;
               for (int k = 0; k < VOICES; k++) begin
                  was          = master_ff && dma_on_ff[k];
                  now          = req_ff.dma_master && req_ff.dma_voice_mask[k];
                  dma_on_in[k] = req_ff.dma_voice_mask[k];
                  if (!was && now) begin
                     live_in[k] = start_ff[k];
                     wl_in[k]   = len_ff[k];
                     mode_in[k] = MODE_READY;
                     mvn_in[k]  = 1'b1;
                  end else if (was && !now) begin
                     mode_in[k] = MODE_IDLE;
                     live_in[k] = '0;
                     wl_in[k]   = '0;
                  end
               end
            end
            OP_SET_ATTACH: begin
               attach_in = {req_ff.period_attach, req_ff.volume_attach};
               for (int k = 0; k < VOICES; k++) begin
                  if (req_ff.period_attach[k] || req_ff.volume_attach[k]) held_in[k] = '0;
               end
            end
            OP_TICK: begin
               if (due) begin
                  tick_in  = '0;
                  valid_in = 1'b1;
               end else begin
                  tick_in = tick_sum[DATA_W-1:0];
               end
            end
            default: read_in = '0;
         endcase
      end
   end

   assign mem_wr  = cmd.exec && (req_ff.op == OP_MEM_WRITE);
   assign wr_idx  = cmd.clear ? cmd.clear_addr : req_ff.mem_address[MEM_AW-1:1];
   assign wr_byte = cmd.clear ? 8'h00 : req_ff.mem_byte;
   assign even_we = cmd.clear || (mem_wr && !req_ff.mem_address[0]);
   assign odd_we  = cmd.clear || (mem_wr && req_ff.mem_address[0]);
   assign rd_idx  = fetch_addr[MEM_AW-1:1];

   always_ff @(posedge clock) begin
      if (even_we) even_mem[wr_idx] <= wr_byte;
      if (odd_we) odd_mem[wr_idx] <= wr_byte;
      even_q_ff <= even_mem[rd_idx];
      odd_q_ff  <= odd_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_data;
      if (cmd.out_load) begin
         rsp_ff.read_data     <= read_ff;
         rsp_ff.left_out      <= left_ff;
         rsp_ff.right_out     <= right_ff;
         rsp_ff.sample_valid  <= valid_ff;
         rsp_ff.irq_flags     <= irq_ff;
         rsp_ff.voices_active <= active;
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= DATA_W'(1);
         tick_ff    <= '0;
         for (int k = 0; k < VOICES; k++) begin
            start_ff[k]  <= '0;
            len_ff[k]    <= '0;
            period_ff[k] <= '0;
            vol_ff[k]    <= '0;
            data_ff[k]   <= '0;
            live_ff[k]   <= '0;
            wl_ff[k]     <= '0;
            mode_ff[k]   <= MODE_IDLE;
            cw_ff[k]     <= '0;
            pc_ff[k]     <= '0;
            held_ff[k]   <= '0;
         end
         dma_on_ff <= '0;
         mvn_ff    <= '1;
         master_ff <= 1'b0;
         attach_ff <= '0;
         irq_ff    <= '0;
         left_ff   <= '0;
         right_ff  <= '0;
         read_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) divider_ff <= csr_write_data;
         tick_ff   <= tick_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         period_ff <= period_in;
         vol_ff    <= vol_in;
         data_ff   <= data_in;
         live_ff   <= live_in;
         wl_ff     <= wl_in;
         mode_ff   <= mode_in;
         cw_ff     <= cw_in;
         pc_ff     <= pc_in;
         held_ff   <= held_in;
         dma_on_ff <= dma_on_in;
         mvn_ff    <= mvn_in;
         master_ff <= master_in;
         attach_ff <= attach_in;
         irq_ff    <= irq_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         read_ff   <= read_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

`default_nettype wire

@@ design/four_voice_dma_sample_player_core.sv @@
// ============================================================================
// Four-voice DMA sample player core
// Request words carry register, DMA, attach, tick and memory-write operations;
// each request gives exactly one response word with the read data, current
// stereo mix, step flag, sticky interrupt bits and active voices.
// Usage: after reset the core runs a clearing pass over every even/odd byte
// pair of the sample memory, one pair per cycle; req_stall stays high
// during that pass. Configuration writes (csr_write_enable) are taken any time.
// Handshake: a request is accepted when req_valid is high and req_stall low.
// Non-stepping operations are decoded, then handed off to raise rsp_valid; a
// tick that completes a sample step is decoded, then walks the four voices,
// each with one sample-memory read and one update, then mixes and hands off.
// One request is in work at a time; the next is accepted right after the
// response word is loaded. While rsp_stall holds the response register, the
// response holds and a new request may still be accepted and worked up to its
// hand-off.
// Reset is synchronous and active high.
// ============================================================================
`default_nettype none

module four_voice_dma_sample_player_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fvdsp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fvdsp_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);
   import fvdsp_pkg::*;

   cmd_type    cmd;
   status_type status;

   fvdsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fvdsp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire

@@ design/fvdsp_checker.sv @@
// ============================================================================
// Four-voice sample player port checker
// Port-level properties on the request and response channels.
// ============================================================================
`default_nettype none

`include "four_voice_dma_sample_player_core_defines.svh"

module fvdsp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input fvdsp_pkg::rsp_type rsp_data
);

   `FVDSP_ASSERT_NOW(clear_after_reset, clock, $past(reset), req_stall)
   `FVDSP_ASSERT_NEXT(one_in_work, clock, reset, req_valid && !req_stall, req_stall)
   `FVDSP_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && rsp_stall,
                      rsp_valid && $stable(rsp_data))

endmodule

bind four_voice_dma_sample_player_core fvdsp_checker u_fvdsp_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Four-voice sample player core testbench
// Drives register, DMA, attach, tick and sample-memory words through the
// request channel, predicts every response word with a behavioral model of the
// voices and the mixer, and compares each response field against it. Random
// request gaps, response stalls, a long response hold-off and several tick dividers.
// ----------------------------------------------------------------------------
module testbench;
   import fvdsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 20;

   class player_scoreboard;
      bit [15:0]  divider;
      bit [15:0]  tick_cnt;
      bit [20:0]  start_ptr[4];
      bit [20:0]  live_ptr[4];
      bit [15:0]  len[4];
      bit [15:0]  period[4];
      bit [15:0]  data_reg[4];
      bit [15:0]  words_left[4];
      bit [15:0]  cur_word[4];
      bit [15:0]  pcount[4];
      bit [6:0]   vol[4];
      mode_type   mode[4];
      bit         dma_on[4];
      int         held[4];
      bit         mod_vol_next[4];
      bit         master;
      bit [7:0]   attach;
      bit [3:0]   irq;
      bit [15:0]  mix_l;
      bit [15:0]  mix_r;
      bit [7:0]   mem[65536];
      rsp_type    expected_q[$];
      int         errors;

      function new();
         divider = 16'd1;
         tick_cnt = '0;
         for (int i = 0; i < 4; i++) begin
            start_ptr[i] = '0; live_ptr[i] = '0; len[i] = '0; period[i] = '0;
            data_reg[i] = '0; words_left[i] = '0; cur_word[i] = '0; pcount[i] = '0;
            vol[i] = '0; mode[i] = MODE_IDLE; dma_on[i] = 0; held[i] = 0;
            mod_vol_next[i] = 1;
         end
         master = 0; attach = '0; irq = '0; mix_l = '0; mix_r = '0; errors = 0;
         for (int a = 0; a < 65536; a++) mem[a] = '0;
      endfunction

      function bit [6:0] vol_limit(bit [15:0] v);
         return (v[6:0] > 7'd64) ? 7'd64 : v[6:0];
      endfunction

      function bit is_attached(int i);
         return attach[i] | attach[i+4];
      endfunction

      function bit [15:0] mem_word(bit [20:0] a);
         bit [15:0] lo;
         lo = a[15:0];
         return {mem[lo], mem[16'(lo + 16'd1)]};
      endfunction

      function bit [15:0] reload(int i);
         return (period[i] == 0) ? 16'd1 : period[i];
      endfunction

      function void play_byte(int i, bit [7:0] b);
         held[i] = int'($signed(b)) * int'(vol[i]);
      endfunction

      function void modulate(int i, bit [15:0] w);
         if (!is_attached(i) || i >= 3) return;
         if (attach[i] && attach[4+i]) begin
            if (mod_vol_next[i]) vol[i+1] = vol_limit(w);
            else period[i+1] = w;
            mod_vol_next[i] = !mod_vol_next[i];
         end else if (attach[i]) begin
            vol[i+1] = vol_limit(w);
         end else begin
            period[i+1] = w;
         end
      endfunction

      function void fetch_and_play(int i);
         cur_word[i] = mem_word(live_ptr[i]);
         live_ptr[i] = live_ptr[i] + 21'd2;
         if (is_attached(i)) begin
            modulate(i, cur_word[i]);
            held[i] = 0;
         end else begin
            play_byte(i, cur_word[i][15:8]);
         end
         mode[i] = MODE_HIGH;
      endfunction

      function bit advance(int i);
         case (mode[i])
            MODE_READY: begin
               fetch_and_play(i);
               return 1;
            end
            MODE_HIGH, MODE_MHIGH: begin
               if (is_attached(i)) held[i] = 0;
               else play_byte(i, cur_word[i][7:0]);
               mode[i] = (mode[i] == MODE_HIGH) ? MODE_LOW : MODE_MLOW;
               return 1;
            end
            MODE_LOW: begin
               if (words_left[i] > 0) words_left[i]--;
               if (words_left[i] == 0) begin
                  live_ptr[i] = start_ptr[i];
                  words_left[i] = len[i];
                  irq[i] = 1;
               end
               fetch_and_play(i);
               return 1;
            end
            MODE_MREADY: begin
               if (is_attached(i)) begin
                  modulate(i, cur_word[i]);
                  held[i] = 0;
                  mode[i] = MODE_MLOW;
               end else begin
                  play_byte(i, cur_word[i][15:8]);
                  mode[i] = MODE_MHIGH;
               end
               return 1;
            end
            MODE_MLOW: begin
               irq[i] = 1;
               mode[i] = MODE_IDLE;
               return 0;
            end
            default: return 0;
         endcase
      endfunction

      function int voice_level(int i);
         if (is_attached(i) || mode[i] == MODE_IDLE || mode[i] == MODE_READY ||
             mode[i] == MODE_MREADY) return 0;
         return held[i];
      endfunction

      function bit [15:0] sat16(int v);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:0];
      endfunction

      function void step_voices();
         for (int i = 0; i < 4; i++) begin
            if (mode[i] == MODE_IDLE) continue;
            if (mode[i] == MODE_READY || mode[i] == MODE_MREADY) begin
               if (advance(i)) pcount[i] = reload(i);
               continue;
            end
            if (pcount[i] == 0) pcount[i] = reload(i);
            pcount[i]--;
            if (pcount[i] == 0 && advance(i)) pcount[i] = reload(i);
         end
         mix_l = sat16(voice_level(0) + voice_level(3));
         mix_r = sat16(voice_level(1) + voice_level(2));
      endfunction

      function void store_reg(int c, bit [2:0] idx, bit [15:0] v);
         case (idx)
            REG_PTR_HIGH: start_ptr[c] = {v[4:0], start_ptr[c][15:1], 1'b0};
            REG_PTR_LOW:  start_ptr[c] = {start_ptr[c][20:16], v[15:1], 1'b0};
            REG_LENGTH:   len[c] = v;
            REG_PERIOD:   period[c] = v;
            REG_VOLUME:   vol[c] = vol_limit(v);
            REG_DATA: begin
               data_reg[c] = v;
               if (!master || !dma_on[c]) begin
                  cur_word[c] = v; words_left[c] = '0; live_ptr[c] = '0;
                  pcount[c] = '0; mode[c] = MODE_MREADY;
               end
            end
            default: ;
         endcase
      endfunction

      function bit [15:0] fetch_reg(int c, bit [2:0] idx);
         case (idx)
            REG_PTR_HIGH: return {11'd0, start_ptr[c][20:16]};
            REG_PTR_LOW:  return {start_ptr[c][15:1], 1'b0};
            REG_LENGTH:   return len[c];
            REG_PERIOD:   return period[c];
            REG_VOLUME:   return {9'd0, vol[c]};
            REG_DATA:     return data_reg[c];
            default:      return '0;
         endcase
      endfunction

      function void set_dma(bit m, bit [3:0] mask);
         bit was, now_on, old_master;
         old_master = master;
         master = m;
         for (int i = 0; i < 4; i++) begin
            was = old_master && dma_on[i];
            now_on = m && mask[i];
            dma_on[i] = mask[i];
            if (!was && now_on) begin
               live_ptr[i] = start_ptr[i]; words_left[i] = len[i];
               mode[i] = MODE_READY; mod_vol_next[i] = 1;
            end else if (was && !now_on) begin
               mode[i] = MODE_IDLE; live_ptr[i] = '0; words_left[i] = '0;
            end
         end
      endfunction

      function void note_word(req_type w);
         rsp_type e;
         bit [16:0] t;
         e = '0;
         case (w.op)
            OP_REG_WRITE:  store_reg(w.channel, w.reg_index, w.value);
            OP_REG_READ:   e.read_data = fetch_reg(w.channel, w.reg_index);
            OP_SET_DMA:    set_dma(w.dma_master, w.dma_voice_mask);
            OP_SET_ATTACH: begin
               attach = {w.period_attach, w.volume_attach};
               for (int i = 0; i < 4; i++) if (is_attached(i)) held[i] = 0;
            end
            OP_TICK: begin
               t = tick_cnt + 17'd1;
               if (t >= divider) begin
                  tick_cnt = '0;
                  step_voices();
                  e.sample_valid = 1;
               end else begin
                  tick_cnt = t[15:0];
               end
            end
            OP_MEM_WRITE: mem[w.mem_address[15:0]] = w.mem_byte;
            default: ;
         endcase
         e.left_out = mix_l;
         e.right_out = mix_r;
         e.irq_flags = irq;
         for (int i = 0; i < 4; i++) e.voices_active[i] = (mode[i] != MODE_IDLE);
         expected_q = {expected_q, e};
      endfunction

      function void check_word(rsp_type r);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, r);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (r.read_data !== e.read_data || r.left_out !== e.left_out ||
             r.right_out !== e.right_out || r.sample_valid !== e.sample_valid ||
             r.irq_flags !== e.irq_flags || r.voices_active !== e.voices_active) begin
            $display("%0t: mismatch expected rd=%h l=%h r=%h sv=%b irq=%h act=%h",
                     $realtime, e.read_data, e.left_out, e.right_out, e.sample_valid,
                     e.irq_flags, e.voices_active);
            $display("%0t:          actual   rd=%h l=%h r=%h sv=%b irq=%h act=%h",
                     $realtime, r.read_data, r.left_out, r.right_out, r.sample_valid,
                     r.irq_flags, r.voices_active);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_write_enable = 0;
   logic [15:0] csr_write_data = '0;

   player_scoreboard sb = new();
   bit idle_on = 1;
   bit long_hold_req = 0;
   int stall_left = 0;
   int cycles = 0;

   four_voice_dma_sample_player_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[four_voice_dma_sample_player_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else if (long_hold_req) begin
            long_hold_req = 0;
            stall_left = 300;
            rsp_stall <= 1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic send_word(input req_type w);
      req_data <= w;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(w);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_divider(input bit [15:0] v);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      sb.divider = v;
      csr_write_enable <= 0;
   endtask

   function automatic req_type noise_word();
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      return r[64:0];
   endfunction

   function automatic req_type make_word(bit [2:0] op, bit [1:0] ch, bit [2:0] idx,
                                         bit [15:0] v);
      req_type w;
      w = noise_word();
      w.op = op; w.channel = ch; w.reg_index = idx; w.value = v;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int r;
      w = noise_word();
      r = $urandom_range(0, 99);
      if (r < 40) begin
         w.op = OP_TICK;
      end else if (r < 56) begin
         w.op = OP_REG_WRITE;
         w.reg_index = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 7) != 0) begin
            case (w.reg_index)
               REG_PTR_HIGH: w.value = $urandom_range(0, 1) ? '0 : w.value;
               REG_PTR_LOW:  w.value = 16'($urandom_range(0, 63));
               REG_LENGTH:   w.value = 16'($urandom_range(0, 3));
               REG_PERIOD:   w.value = 16'($urandom_range(0, 3));
               default: ;
            endcase
         end
      end else if (r < 64) begin
         w.op = OP_REG_READ;
      end else if (r < 70) begin
         w.op = OP_SET_DMA;
         w.dma_master = ($urandom_range(0, 4) != 0);
      end else if (r < 74) begin
         w.op = OP_SET_ATTACH;
         if ($urandom_range(0, 2) != 0) begin
            w.volume_attach = '0;
            w.period_attach = '0;
         end
      end else if (r < 97) begin
         w.op = OP_MEM_WRITE;
         if ($urandom_range(0, 5) != 0) w.mem_address[15:0] = 16'($urandom_range(0, 127));
      end else begin
         w.op = 3'($urandom_range(6, 7));
      end
      return w;
   endfunction

   initial begin
      req_type w;
      bit [15:0] dividers[6];
      dividers = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd1};
      repeat (6) @(posedge clock);
      reset <= 0;
      write_divider(16'd1);

      w = make_word(OP_MEM_WRITE, 0, 0, 0);
      w.mem_address = 20'd0;     w.mem_byte = 8'h80; send_word(w);
      w.mem_address = 20'd1;     w.mem_byte = 8'h7F; send_word(w);
      w.mem_address = 20'hFFFFF; w.mem_byte = 8'hFF; send_word(w);
      w.mem_address = 20'h10002; w.mem_byte = 8'h01; send_word(w);
      send_word(make_word(OP_REG_WRITE, 0, REG_PTR_HIGH, 16'hFFFF));
      send_word(make_word(OP_REG_WRITE, 0, REG_PTR_LOW, 16'hFFFF));
      send_word(make_word(OP_REG_WRITE, 0, REG_VOLUME, 16'hFFFF));
      send_word(make_word(OP_REG_WRITE, 1, REG_VOLUME, 16'h0040));
      send_word(make_word(OP_REG_WRITE, 0, 3'd6, 16'h1234));
      for (int k = 0; k < 8; k++) send_word(make_word(OP_REG_READ, 0, 3'(k), 0));
      send_word(make_word(3'd6, 0, 0, 0));
      send_word(make_word(3'd7, 0, 0, 0));
      w = make_word(OP_SET_DMA, 0, 0, 0);
      w.dma_master = 1; w.dma_voice_mask = 4'hF; send_word(w);
      for (int k = 0; k < 4; k++) send_word(make_word(OP_TICK, 0, 0, 0));
      send_word(make_word(OP_REG_WRITE, 1, REG_DATA, 16'h807F));
      w = make_word(OP_SET_ATTACH, 0, 0, 0);
      w.volume_attach = 4'hF; w.period_attach = 4'hF; send_word(w);
      for (int k = 0; k < 3; k++) send_word(make_word(OP_TICK, 0, 0, 0));
      w = make_word(OP_SET_DMA, 0, 0, 0);
      w.dma_master = 0; w.dma_voice_mask = 4'h0; send_word(w);
      send_word(make_word(OP_REG_WRITE, 2, REG_DATA, 16'h7F80));
      for (int k = 0; k < 4; k++) send_word(make_word(OP_TICK, 0, 0, 0));
      wait_drain();

      for (int p = 0; p < 6; p++) begin
         write_divider(dividers[p]);
         if (p == 5) idle_on = 0;
         if (p == 2) long_hold_req = 1;
         for (int k = 0; k < 170; k++) send_word(random_word());
         wait_drain();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("[four_voice_dma_sample_player_core] OK");
      else
         $display("[four_voice_dma_sample_player_core] ERROR");
      $finish;
   end
endmodule
